@@ rtl/spa_pkg.sv @@
// Package with the types, constants and command structures of the slot pool allocator.
`default_nettype none

package spa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int CFG_W     = 9;

    localparam logic [LINK_W-1:0] LINK_EMPTY = LINK_W'(MAX_SLOTS);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              success;
    } t_resp;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/spa_ctrl.sv @@
// Controller state machine that sequences each request through capture and execution.
`default_nettype none

module spa_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire spa_pkg::t_stat i_stat,
    output spa_pkg::t_cmd     o_cmd
);
    import spa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.out_blocked) begin
                    o_cmd.execute = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/spa_dp.sv @@
// Datapath with the bump counter, free-list head, link memory and result register.
`default_nettype none

module spa_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire spa_pkg::t_req            i_in_data,
    input  wire logic                     i_cfg_we,
    input  wire logic [spa_pkg::CFG_W-1:0] i_cfg_data,
    input  wire spa_pkg::t_cmd            i_cmd,
    output spa_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output spa_pkg::t_resp                o_out_data
);
    import spa_pkg::*;

    logic [LINK_W-1:0] mem [MAX_SLOTS];

    t_req              r_req;
    logic [CFG_W-1:0]  r_slot_count;
    logic [LINK_W-1:0] r_bump;
    logic [LINK_W-1:0] n_bump;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] n_head;
    logic [LINK_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic              n_out_valid;
    t_resp             r_out_data;
    t_resp             n_resp;
    logic              w_we;
    logic [LINK_W-1:0] w_count;
    logic [LINK_W-1:0] w_idx_ext;

    assign w_count   = (r_slot_count >= CFG_W'(MAX_SLOTS)) ? LINK_W'(MAX_SLOTS)
                                                          : LINK_W'(r_slot_count);
    assign w_idx_ext = {1'b0, r_req.slot_index};

    always_comb begin
        n_bump = r_bump;
        n_head = r_head;
        n_resp = '0;
        w_we   = 1'b0;
        if (r_req.kind == KIND_ALLOC) begin
            if (!r_head[LINK_W-1]) begin
                n_resp.granted_slot = r_head[SLOT_W-1:0];
                n_resp.success      = 1'b1;
                n_head              = r_rd_data;
            end else if (r_bump < w_count) begin
                n_resp.granted_slot = r_bump[SLOT_W-1:0];
                n_resp.success      = 1'b1;
                n_bump              = r_bump + LINK_W'(1);
            end
        end else begin
            if (w_idx_ext < w_count) begin
                n_resp.success = 1'b1;
                if ((r_bump != '0) && (w_idx_ext == r_bump - LINK_W'(1))) begin
                    n_bump = r_bump - LINK_W'(1);
                end else begin
                    w_we   = 1'b1;
                    n_head = w_idx_ext;
                end
            end
        end
    end

    assign n_out_valid = i_cmd.execute ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_head[SLOT_W-1:0]];
        if (i_cmd.execute && w_we) begin
            mem[r_req.slot_index] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        if (i_cmd.execute) begin
            r_out_data <= n_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= CFG_W'(MAX_SLOTS);
            r_bump       <= '0;
            r_head       <= LINK_EMPTY;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_data;
            end
            if (i_cmd.execute) begin
                r_bump <= n_bump;
                r_head <= n_head;
            end
        end
    end

    assign o_stat.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

endmodule

`default_nettype wire

@@ rtl/slot_pool_allocator_unit.sv @@
// Top level of the slot pool allocator.
`default_nettype none

// The block hands out and takes back slots of a pool by index. An allocate
// transaction pops the free-list head or, with the list empty, takes the next
// never-used slot; a free transaction pushes the slot or lowers the bump count.
// Each request is accepted in one state and executed in another, since
// the link of the current head comes from a synchronous link memory with a
// registered read. The result waits in an output register, so a new request
// is accepted while the previous result is still stalled. The slot count is
// written through the configuration channel, which is always ready.

module slot_pool_allocator_unit (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire spa_pkg::t_req            i_in_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output spa_pkg::t_resp                o_out_data,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [spa_pkg::CFG_W-1:0] i_cfg_data
);
    import spa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    spa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the slot pool allocator: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;

    import spa_pkg::*;

    localparam int ON_ACCEPT   = 0;
    localparam int ON_QUEUE    = 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int N_PHASES    = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_req                 i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_resp                o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Two copies of the pool: one advanced as requests are queued, to steer
    // the stimulus, and one advanced as the block accepts them.
    logic [CFG_W-1:0]     pool_count [2];
    logic [LINK_W-1:0]    bump_count [2];
    logic [LINK_W-1:0]    free_head  [2];
    logic [LINK_W-1:0]    next_link  [2][MAX_SLOTS];

    t_req                 pending_reqs [$];
    t_resp                awaited_resps [$];
    logic [SLOT_W-1:0]    live_slots [$];

    int                   n_errors = 0;
    int                   n_results = 0;
    int                   n_cycles = 0;
    int                   gap_max = 2;
    int                   stall_pct = 30;
    int                   burst_left = 0;
    int                   gap_left = 0;
    int                   hold_left = 0;
    bit                   long_hold_done = 1'b0;

    int phase_cfg   [N_PHASES] = '{511, 256, 5, 0, 1, 300, 40, 2, 130, 256};
    int phase_items [N_PHASES] = '{380, 200, 150, 60, 80, 200, 280, 90, 230, 230};
    int phase_alloc [N_PHASES] = '{85, 45, 55, 50, 50, 40, 60, 50, 55, 35};

    slot_pool_allocator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_resp pool_step(input int m, input t_req req);
        t_resp r;
        int    usable;
        r = '0;
        usable = (int'(pool_count[m]) > MAX_SLOTS) ? MAX_SLOTS : int'(pool_count[m]);
        if (req.kind == KIND_ALLOC) begin
            if (free_head[m] != LINK_EMPTY) begin
                r.granted_slot = free_head[m][SLOT_W-1:0];
                r.success      = 1'b1;
                free_head[m]   = next_link[m][free_head[m][SLOT_W-1:0]];
            end else if (int'(bump_count[m]) < usable) begin
                r.granted_slot = bump_count[m][SLOT_W-1:0];
                r.success      = 1'b1;
                bump_count[m]  = bump_count[m] + 1'b1;
            end
        end else if (int'(req.slot_index) < usable) begin
            r.success = 1'b1;
            if (bump_count[m] != 0 && int'(req.slot_index) == int'(bump_count[m]) - 1) begin
                bump_count[m] = bump_count[m] - 1'b1;
            end else begin
                next_link[m][req.slot_index] = free_head[m];
                free_head[m] = {1'b0, req.slot_index};
            end
        end
        return r;
    endfunction

    function automatic void note_error(input string msg);
        if (n_errors < 10) begin
            $display("%s", msg);
        end
        n_errors++;
    endfunction

    task automatic queue_request(input logic kind, input logic [SLOT_W-1:0] idx);
        t_req  req;
        t_resp r;
        int    pos;
        req.kind       = kind;
        req.slot_index = idx;
        r = pool_step(ON_QUEUE, req);
        if (kind == KIND_ALLOC && r.success) begin
            live_slots.push_back(r.granted_slot);
        end else if (kind == KIND_FREE && r.success) begin
            pos = -1;
            foreach (live_slots[i]) begin
                if (pos < 0 && live_slots[i] == idx) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                live_slots.delete(pos);
            end
        end
        pending_reqs.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_in_valid || awaited_resps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_slot_count(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pool_count[ON_ACCEPT] = value;
        pool_count[ON_QUEUE]  = value;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : sender
        t_resp r;
        logic  nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r = pool_step(ON_ACCEPT, i_in_data);
                awaited_resps.push_back(r);
            end
            if (!i_in_valid || !o_in_stall) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    nxt_valid = 1'b1;
                    i_in_data <= pending_reqs.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
                    end
                end
                i_in_valid <= nxt_valid;
            end
        end
    end

    // Receiver: random stalls, occasional long hold-offs, one forced early on.
    always @(posedge i_clk) begin : receiver
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!long_hold_done && n_results >= 150) begin
            long_hold_done = 1'b1;
            hold_left      = 300;
            i_out_stall   <= 1'b1;
        end else if ($urandom_range(2999, 0) == 0) begin
            hold_left    = $urandom_range(200, 40);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_resp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (awaited_resps.size() == 0) begin
                note_error($sformatf("Unexpected result: granted_slot %0d success %0d",
                                     o_out_data.granted_slot, o_out_data.success));
            end else begin
                want = awaited_resps.pop_front();
                if (o_out_data.granted_slot !== want.granted_slot
                    || o_out_data.success !== want.success) begin
                    note_error($sformatf(
                        "Result %0d: expected granted_slot %0d success %0d, got %0d %0d",
                        n_results, want.granted_slot, want.success,
                        o_out_data.granted_slot, o_out_data.success));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("[slot_pool_allocator_unit] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int              usable;
        int              pick;
        logic [SLOT_W-1:0] a_slot;
        logic [SLOT_W-1:0] b_slot;
        for (int m = 0; m < 2; m++) begin
            pool_count[m] = CFG_W'(256);
            bump_count[m] = '0;
            free_head[m]  = LINK_EMPTY;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                next_link[m][i] = '0;
            end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(KIND_ALLOC, 8'hFF);
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_ALLOC, 8'hAA);
        queue_request(KIND_FREE, 8'd1);
        queue_request(KIND_FREE, 8'd2);
        queue_request(KIND_ALLOC, 8'h55);
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_FREE, 8'd0);
        queue_request(KIND_ALLOC, 8'h00);
        set_slot_count(CFG_W'(3));
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_FREE, 8'd255);
        queue_request(KIND_FREE, 8'd3);
        queue_request(KIND_FREE, 8'd2);
        queue_request(KIND_ALLOC, 8'h00);
        set_slot_count(CFG_W'(0));
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_FREE, 8'd0);
        set_slot_count(CFG_W'(1));
        queue_request(KIND_FREE, 8'd1);
        queue_request(KIND_FREE, 8'd0);
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_ALLOC, 8'h00);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_slot_count(CFG_W'(phase_cfg[ph]));
            gap_max   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 12);
            stall_pct = (ph % 4 == 0) ? 0 : ((ph % 4 == 1) ? 20 : ((ph % 4 == 2) ? 50 : 75));
            usable    = (phase_cfg[ph] > MAX_SLOTS) ? MAX_SLOTS : phase_cfg[ph];
            for (int n = 0; n < phase_items[ph]; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < phase_alloc[ph]) begin
                    queue_request(KIND_ALLOC, SLOT_W'($urandom_range(255, 0)));
                end else if (pick < phase_alloc[ph] + 8 && usable < MAX_SLOTS) begin
                    queue_request(KIND_FREE, SLOT_W'($urandom_range(255, usable)));
                end else if (live_slots.size() == 0) begin
                    queue_request(KIND_ALLOC, SLOT_W'($urandom_range(255, 0)));
                end else if ($urandom_range(99, 0) < 35) begin
                    queue_request(KIND_FREE, live_slots[live_slots.size() - 1]);
                end else begin
                    queue_request(KIND_FREE,
                                  live_slots[$urandom_range(live_slots.size() - 1, 0)]);
                end
            end
        end

        // A slot freed twice closes a loop in the free list.
        wait_drained();
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_ALLOC, 8'h00);
        a_slot = live_slots[live_slots.size() - 2];
        b_slot = live_slots[live_slots.size() - 1];
        queue_request(KIND_FREE, a_slot);
        queue_request(KIND_FREE, a_slot);
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_ALLOC, 8'h00);
        queue_request(KIND_FREE, b_slot);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (awaited_resps.size() != 0) begin
            note_error($sformatf("%0d results never arrived", awaited_resps.size()));
        end
        if (n_errors == 0) begin
            $display("[slot_pool_allocator_unit] OK");
        end else begin
            $display("[slot_pool_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/spa_pkg.sv
rtl/spa_ctrl.sv
rtl/spa_dp.sv
rtl/slot_pool_allocator_unit.sv
tb/tb.sv
